[src/itrt_pkg.sv]
// ----------------------------------------------------------------------------
// itrt_pkg
// shared constants, types and the digit-to-character map for the radix
// text converter
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int VALUE_W        = 64;
  localparam int BASE_W         = 6;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [BASE_W-1:0] RADIX_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] RADIX_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] RADIX_RESET = BASE_W'(10);

  // quotient bits resolved per divider cycle
  localparam int STEP_BITS  = 8;
  localparam int DIV_STEPS  = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
  localparam logic [BASE_W-1:0] DEC_DIGITS = BASE_W'(10);

  typedef struct packed {
    logic load;        // latch value and base, clear digit count
    logic div_step;    // resolve one group of quotient bits
    logic digit_done;  // store remainder as a digit
    logic rd_en;       // read one digit out, most significant first
  } cmd_t;

  typedef struct packed {
    logic quot_zero;   // quotient has reached zero
    logic full;        // digit store holds its last allowed digit after this one
    logic rd_last;     // read pointer sits at the least significant digit
  } stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] r);
    logic [BASE_W-1:0] v;
    if (r < RADIX_MIN) begin
      v = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      v = RADIX_MAX;
    end else begin
      v = r;
    end
    return v;
  endfunction

endpackage

[src/itrt_ctrl.sv]
// ----------------------------------------------------------------------------
// itrt_ctrl
// sequencer: divide, store, repeat until quotient zero or store full, read out
// ----------------------------------------------------------------------------
module itrt_ctrl import itrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_t;

  state_t                state;
  logic [STEP_CNT_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == STEP_CNT_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            state <= S_STORE;
          end else begin
            step <= step + STEP_CNT_W'(1);
          end
        end
        S_STORE: begin
          if (stat.quot_zero || stat.full) begin
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_EMIT: begin
          if (stat.rd_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && start;
    cmd.div_step   = (state == S_DIV);
    cmd.digit_done = (state == S_STORE);
    cmd.rd_en      = (state == S_EMIT);
  end

endmodule

[src/itrt_dp.sv]
// ----------------------------------------------------------------------------
// itrt_dp
// radix register, shift-subtract divider, digit store and output registers
// ----------------------------------------------------------------------------
module itrt_dp import itrt_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BASE_W-1:0]  cfg_data,
  input  logic [VALUE_W-1:0] value,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               digit_valid,
  output logic [CHAR_W-1:0]  digit_char,
  output logic [COUNT_W-1:0] digit_count,
  output logic               is_last
);

  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [BASE_W-1:0]  radix;
  logic [BASE_W-1:0]  base;
  logic [VALUE_W-1:0] quot;
  logic [BASE_W-1:0]  rem;
  logic [COUNT_W-1:0] n;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [CHAR_W-1:0]  mem [MAX_DIGITS];

  logic [VALUE_W-1:0] quot_next;
  logic [BASE_W-1:0]  rem_next;

  // eight restoring steps on a remainder that stays below the base
  always_comb begin
    logic [VALUE_W-1:0] q;
    logic [BASE_W:0]    r;
    q = quot;
    r = {1'b0, rem};
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[BASE_W-1:0], q[VALUE_W-1]};
      q = {q[VALUE_W-2:0], 1'b0};
      if (r >= {1'b0, base}) begin
        r    = r - {1'b0, base};
        q[0] = 1'b1;
      end
    end
    quot_next = q;
    rem_next  = r[BASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= clamp_radix(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.load) begin
      n <= '0;
    end else if (cmd.digit_done) begin
      n <= n + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot <= value;
      rem  <= '0;
      base <= radix;
    end else if (cmd.div_step) begin
      quot <= quot_next;
      rem  <= rem_next;
    end else if (cmd.digit_done) begin
      rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_done) begin
      mem[n[ADDR_W-1:0]] <= digit_to_char(rem);
      rd_ptr             <= n[ADDR_W-1:0];
    end else if (cmd.rd_en) begin
      rd_ptr <= rd_ptr - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      digit_char  <= mem[rd_ptr];
      digit_count <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
      is_last     <= 1'b0;
    end else begin
      digit_valid <= cmd.rd_en;
      is_last     <= cmd.rd_en && (rd_ptr == '0);
    end
  end

  always_comb begin
    stat           = '0;
    stat.quot_zero = (quot == '0);
    stat.full      = (n == COUNT_W'(MAX_DIGITS - 1));
    stat.rd_last   = (rd_ptr == '0);
  end

endmodule

[src/integer_to_radix_text.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_text
// unsigned 64-bit integer to ASCII text in a programmable base
// ----------------------------------------------------------------------------
// Converts value to its digits in base radix (2..36, reset 10; writes outside
// that range clamp to the nearest end). A transfer is taken when start is high
// and busy is low; the base is captured at that point. Digits come out most
// significant first, one per cycle, each marked by a one-cycle digit_valid
// strobe with digit_count and is_last alongside; the receiver cannot stall.
// Each digit is worked out in the shared shift-subtract divider, 8 quotient
// bits per divider cycle, then stored; once the loop ends, the digits stream
// out of the digit store at one per cycle. The first digit strobe follows the
// store of the last digit through the readout state and the output registers,
// and the final strobe lands in the cycle after busy drops.
// ----------------------------------------------------------------------------
module integer_to_radix_text import itrt_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  // base register write
  input  logic               cfg_we,
  input  logic [BASE_W-1:0]  cfg_data,
  // digit stream
  output logic               digit_valid,
  output logic [CHAR_W-1:0]  digit_char,
  output logic [COUNT_W-1:0] digit_count,
  output logic               is_last
);

  cmd_t  cmd;   // sequencer commands to the datapath
  stat_t stat;  // datapath status back to the sequencer

  // sequencer: divide / store loop, then readout
  itrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // divider, digit store and registered outputs
  itrt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .digit_valid (digit_valid),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .is_last     (is_last)
  );

endmodule

[src/itrt_checker.sv]
// ----------------------------------------------------------------------------
// itrt_checker
// port-level checks on the digit stream of the radix text converter
// ----------------------------------------------------------------------------
module itrt_checker import itrt_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               digit_valid,
  input logic [CHAR_W-1:0]  digit_char,
  input logic [COUNT_W-1:0] digit_count,
  input logic               is_last
);

  // an accepted transfer always raises busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transfer");

  // characters stay within '0'..'9' and 'A'..'Z'
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> ((digit_char >= CHAR_W'(48) && digit_char <= CHAR_W'(57)) ||
                     (digit_char >= CHAR_W'(65) && digit_char <= CHAR_W'(90))))
    else $error("digit character out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_count >= COUNT_W'(1) &&
                     digit_count <= COUNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  // digits of one number stream without gaps and share one count
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !is_last |=> digit_valid && $stable(digit_count))
    else $error("gap or count change inside a digit stream");

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    is_last |-> digit_valid)
    else $error("last marker without strobe");

endmodule

bind integer_to_radix_text itrt_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_itrt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .digit_valid (digit_valid),
  .digit_char  (digit_char),
  .digit_count (digit_count),
  .is_last     (is_last)
);
